FILE: hdl/gq_pkg.sv
// Shared constants, types and controller/datapath handshake structs of the gray quantizer.
`timescale 1ns / 1ps
`default_nettype none

package gq_pkg;

   localparam int COLOR_W     = 8;
   localparam int TONE_W      = 9;
   localparam int LUM_W       = 18;
   localparam int DIV_W       = 18;
   localparam int DIV_SHORT_W = 10;
   localparam int MUL_W       = 19;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 29;
   localparam int PROD_W      = MUL_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   // ceil(2^29 / 1000): exact floor(x / 1000) for every x below 2^19
   localparam logic [RECIP_W-1:0] RECIP_MILLI = 20'd536871;

   localparam logic [LUM_W-1:0] COEF_RED    = 18'd299;
   localparam logic [LUM_W-1:0] COEF_GREEN  = 18'd587;
   localparam logic [LUM_W-1:0] COEF_BLUE   = 18'd114;
   localparam logic [LUM_W-1:0] MILLI       = 18'd1000;
   localparam logic [LUM_W-1:0] HALF_MILLI  = 18'd500;

   localparam logic [TONE_W-1:0]  TONES_FULL = 9'd256;
   localparam logic [COLOR_W-1:0] GRAY_MAX   = 8'd255;

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [TONE_W-1:0]  tone_type;
   typedef logic [LUM_W-1:0]   lum_type;

   typedef enum logic [1:0] {
      MUL_LUM,
      MUL_DIFF,
      MUL_HALF
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        set_gray;
      logic        set_pos;
      logic        div_start;
      logic        div_short;
      logic        set_w;
      logic        set_half;
      logic        set_center;
      logic        load_out;
      logic        out_binned;
   } gq_cmd_type;

   typedef struct packed {
      logic op;
      logic tones_ge_span;
      logic pos_below_min;
      logic idx_out;
      logic div_done;
      logic out_busy;
   } gq_status_type;

endpackage

`default_nettype wire

FILE: hdl/gq_channels.sv
// Valid/ready channel interfaces: pixel requests, gray responses and the tone-count write port.
`timescale 1ns / 1ps
`default_nettype none

interface gq_req_if import gq_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      op;
   logic      first;
   color_type red;
   color_type green;
   color_type blue;

   modport source (output valid, output op, output first, output red, output green,
                   output blue, input ready);
   modport sink   (input valid, input op, input first, input red, input green,
                   input blue, output ready);
endinterface

interface gq_rsp_if import gq_pkg::*; ();
   logic      valid;
   logic      ready;
   color_type gray;
   logic      binned;

   modport source (output valid, output gray, output binned, input ready);
   modport sink   (input valid, input gray, input binned, output ready);
endinterface

interface gq_csr_if import gq_pkg::*; ();
   logic     valid;
   logic     ready;
   tone_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/gq_divider.sv
// Iterative restoring divider, two quotient bits per cycle, with a short mode for narrow dividends.
`timescale 1ns / 1ps
`default_nettype none

module gq_divider import gq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             short_mode,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIV_W / 2);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W:0]   step_a, step_b;

   // one restoring step: returns {quotient bit, new partial remainder}
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [DIV_W-1:0] den);
      logic [DIV_W:0] trial;
      logic [DIV_W:0] result;
      trial = {rem, bit_in};
      if (trial >= {1'b0, den}) begin
         result = {1'b1, DIV_W'(trial - {1'b0, den})};
      end else begin
         result = {1'b0, trial[DIV_W-1:0]};
      end
      return result;
   endfunction

   always_comb begin
      step_a  = div_step(rem_ff, quo_ff[DIV_W-1], div_ff);
      step_b  = div_step(step_a[DIV_W-1:0], quo_ff[DIV_W-2], div_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         div_in  = divisor;
         if (short_mode) begin
            // left-align the narrow dividend so fewer steps finish it
            quo_in = dividend << (DIV_W - DIV_SHORT_W);
            cnt_in = CNT_W'(DIV_SHORT_W / 2 - 1);
         end else begin
            quo_in = dividend;
            cnt_in = CNT_W'(DIV_W / 2 - 1);
         end
      end else if (busy_ff) begin
         rem_in = step_b[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-3:0], step_a[DIV_W], step_b[DIV_W]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hdl/gq_datapath.sv
// Datapath: luminance, reciprocal-multiply by 1000, min/max tracking, bin math and output register.
`timescale 1ns / 1ps
`default_nettype none

module gq_datapath import gq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  gq_cmd_type    cmd,
   output gq_status_type status,
   input  logic          req_op,
   input  logic          req_first,
   input  color_type     req_red,
   input  color_type     req_green,
   input  color_type     req_blue,
   input  logic          csr_valid,
   input  tone_type      csr_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output color_type     rsp_gray,
   output logic          rsp_binned
);

   logic              op_ff, op_in;
   logic              first_ff, first_in;
   lum_type           lum_ff, lum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   color_type         gray_ff, gray_in;
   lum_type           min_ff, min_in;
   lum_type           max_ff, max_in;
   lum_type           diff_ff, diff_in;
   lum_type           pos_ff, pos_in;
   lum_type           wk_ff, wk_in;
   lum_type           wh_ff, wh_in;
   logic [MUL_W-1:0]  half_ff, half_in;
   color_type         center_ff, center_in;
   tone_type          tone_count_ff, tone_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   color_type         rsp_gray_ff, rsp_gray_in;
   logic              rsp_binned_ff, rsp_binned_in;

   logic [MUL_W-1:0]  mul_x;
   logic [QUOT_W-1:0] milli_quot;
   tone_type          tones;
   tone_type          span;
   tone_type          w_quot;
   logic [DIV_W-1:0]  div_dividend, div_divisor, div_quot, div_rem;
   logic              div_done;

   gq_divider u_gq_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start),
      .short_mode (cmd.div_short),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .done       (div_done),
      .quotient   (div_quot),
      .remainder  (div_rem)
   );

   always_comb begin
      case (cmd.mul_sel)
         MUL_LUM:  mul_x = MUL_W'(lum_ff);
         MUL_DIFF: mul_x = MUL_W'(diff_ff);
         MUL_HALF: mul_x = half_ff;
         default:  mul_x = MUL_W'(lum_ff);
      endcase
   end

   assign prod_in    = PROD_W'(mul_x) * PROD_W'(RECIP_MILLI);
   assign milli_quot = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign tones      = (tone_count_ff == '0) ? TONES_FULL : tone_count_ff;
   assign span       = TONE_W'(milli_quot) + TONE_W'(1);
   assign w_quot     = div_quot[TONE_W-1:0];

   assign div_dividend = cmd.div_short ? DIV_W'(span) : DIV_W'(pos_ff - min_ff);
   assign div_divisor  = cmd.div_short ? DIV_W'(tones) : DIV_W'(wk_ff);

   always_comb begin
      op_in         = op_ff;
      first_in      = first_ff;
      lum_in        = lum_ff;
      gray_in       = gray_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      diff_in       = diff_ff;
      pos_in        = pos_ff;
      wk_in         = wk_ff;
      wh_in         = wh_ff;
      half_in       = half_ff;
      center_in     = center_ff;
      tone_count_in = csr_valid ? csr_data : tone_count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_gray_in   = rsp_gray_ff;
      rsp_binned_in = rsp_binned_ff;

      if (cmd.load_in) begin
         op_in    = req_op;
         first_in = req_first;
         lum_in   = LUM_W'(req_red) * COEF_RED + LUM_W'(req_green) * COEF_GREEN
                    + LUM_W'(req_blue) * COEF_BLUE;
      end
      if (cmd.set_gray) begin
         gray_in = milli_quot[COLOR_W-1:0];
         diff_in = (max_ff >= min_ff) ? max_ff - min_ff : '0;
         // the first flag restarts tracking only in the analysis pass
         if (!op_ff) begin
            if (first_ff) begin
               min_in = lum_ff;
               max_in = lum_ff;
            end else begin
               if (lum_ff < min_ff) min_in = lum_ff;
               if (lum_ff > max_ff) max_in = lum_ff;
            end
         end
      end
      if (cmd.set_pos) begin
         pos_in = LUM_W'(gray_ff) * MILLI + HALF_MILLI;
      end
      if (cmd.set_w) begin
         wk_in = LUM_W'(w_quot) * MILLI;
         wh_in = (LUM_W'(w_quot) - LUM_W'(1)) * HALF_MILLI;
      end
      // pos - remainder equals min + idx * width * 1000, so the center needs no multiply by idx
      if (cmd.set_half) begin
         half_in = MUL_W'(pos_ff) - MUL_W'(div_rem) + MUL_W'(wh_ff);
      end
      if (cmd.set_center) begin
         center_in = (milli_quot > QUOT_W'(GRAY_MAX)) ? GRAY_MAX : milli_quot[COLOR_W-1:0];
      end
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_gray_in   = cmd.out_binned ? center_ff : gray_ff;
         rsp_binned_in = cmd.out_binned;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff        <= '0;
         max_ff        <= '0;
         tone_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_ff        <= min_in;
         max_ff        <= max_in;
         tone_count_ff <= tone_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      first_ff      <= first_in;
      lum_ff        <= lum_in;
      prod_ff       <= prod_in;
      gray_ff       <= gray_in;
      diff_ff       <= diff_in;
      pos_ff        <= pos_in;
      wk_ff         <= wk_in;
      wh_ff         <= wh_in;
      half_ff       <= half_in;
      center_ff     <= center_in;
      rsp_gray_ff   <= rsp_gray_in;
      rsp_binned_ff <= rsp_binned_in;
   end

   assign status.op            = op_ff;
   assign status.tones_ge_span = (tones >= span);
   assign status.pos_below_min = (pos_ff < min_ff);
   assign status.idx_out       = (div_quot >= DIV_W'(tones));
   assign status.div_done      = div_done;
   assign status.out_busy      = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_gray   = rsp_gray_ff;
   assign rsp_binned = rsp_binned_ff;

endmodule

`default_nettype wire

FILE: hdl/gq_ctrl.sv
// Controller: sequences the analysis and quantize steps of one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module gq_ctrl import gq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  gq_status_type status,
   output gq_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_LUM,
      S_GRAY,
      S_MUL_SPAN,
      S_SPAN,
      S_W_DIV,
      S_IDX_START,
      S_IDX_DIV,
      S_MUL_HALF,
      S_CENTER,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      binned_ff, binned_in;

   always_comb begin
      state_in  = state_ff;
      binned_in = binned_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               binned_in   = 1'b0;
               state_in    = S_MUL_LUM;
            end
         end
         S_MUL_LUM: begin
            cmd.mul_sel = MUL_LUM;
            state_in    = S_GRAY;
         end
         S_GRAY: begin
            cmd.set_gray = 1'b1;
            state_in     = status.op ? S_MUL_SPAN : S_DONE;
         end
         S_MUL_SPAN: begin
            cmd.mul_sel = MUL_DIFF;
            cmd.set_pos = 1'b1;
            state_in    = S_SPAN;
         end
         S_SPAN: begin
            // enough tones to cover the span: keep plain gray
            if (status.tones_ge_span) begin
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_short = 1'b1;
               state_in      = S_W_DIV;
            end
         end
         S_W_DIV: begin
            if (status.div_done) begin
               cmd.set_w = 1'b1;
               state_in  = status.pos_below_min ? S_DONE : S_IDX_START;
            end
         end
         S_IDX_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_IDX_DIV;
         end
         S_IDX_DIV: begin
            if (status.div_done) begin
               // past the last interval: keep plain gray
               if (status.idx_out) begin
                  state_in = S_DONE;
               end else begin
                  cmd.set_half = 1'b1;
                  state_in     = S_MUL_HALF;
               end
            end
         end
         S_MUL_HALF: begin
            cmd.mul_sel = MUL_HALF;
            state_in    = S_CENTER;
         end
         S_CENTER: begin
            cmd.set_center = 1'b1;
            binned_in      = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            // hold until the output register frees up
            if (!status.out_busy) begin
               cmd.load_out   = 1'b1;
               cmd.out_binned = binned_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         binned_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         binned_ff <= binned_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

FILE: hdl/gray_quantizer.sv
// Gray quantizer top level: one item is in work at a time, and the next is taken only once
// the controller is idle again. Quantize pass items go through the shared divider twice,
// once for the bin width and once for the bin index, and so take longest.
// Items that stay plain gray leave early. A result waiting in the output register
// stalls the next one only at its final step.
// Synchronous reset clears min/max luminance and tone count to zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gray_quantizer import gq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   gq_req_if.sink   req_ch,
   gq_rsp_if.source rsp_ch,
   gq_csr_if.sink   csr_ch
);

   gq_cmd_type    cmd;
   gq_status_type status;

   assign csr_ch.ready = 1'b1;

   gq_ctrl u_gq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gq_datapath u_gq_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_ch.op),
      .req_first  (req_ch.first),
      .req_red    (req_ch.red),
      .req_green  (req_ch.green),
      .req_blue   (req_ch.blue),
      .csr_valid  (csr_ch.valid),
      .csr_data   (csr_ch.data),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_gray   (rsp_ch.gray),
      .rsp_binned (rsp_ch.binned)
   );

endmodule

`default_nettype wire

FILE: hdl/gq_checker.sv
// Port-level checker for the gray quantizer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gq_checker import gq_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input color_type rsp_gray,
   input logic      rsp_binned,
   input logic      csr_ready
);

   // one item at a time: an accepted item closes the input for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted twice in a row");

   // a result is posted in the same step that reopens the input
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result posted while an item is still in work");

   // leaving reset the block is idle and open
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid && csr_ready)
      else $error("not idle after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gray) && $stable(rsp_binned))
      else $error("stalled result changed");

endmodule

bind gray_quantizer gq_checker u_gq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_gray   (rsp_ch.gray),
   .rsp_binned (rsp_ch.binned),
   .csr_ready  (csr_ch.ready)
);

`default_nettype wire
